[src/svia_pkg.sv]
// Shared types, opcodes and constants for the stack VM integer ALU.
// No dependencies.
package svia_pkg;

    localparam int DATA_WIDTH_DEF = 64;

    typedef enum logic [4:0] {
        OP_ADD1    = 5'd0,
        OP_SUB1    = 5'd1,
        OP_DOUBLE  = 5'd2,
        OP_HALVE   = 5'd3,
        OP_NEGATE  = 5'd4,
        OP_ABS     = 5'd5,
        OP_NOT     = 5'd6,
        OP_NONZERO = 5'd7,
        OP_ADD     = 5'd8,
        OP_SUB     = 5'd9,
        OP_MUL     = 5'd10,
        OP_DIV     = 5'd11,
        OP_MOD     = 5'd12,
        OP_SHL     = 5'd13,
        OP_SHR     = 5'd14,
        OP_BOOLAND = 5'd15,
        OP_BOOLOR  = 5'd16,
        OP_EQ      = 5'd17,
        OP_EQVER   = 5'd18,
        OP_NE      = 5'd19,
        OP_LT      = 5'd20,
        OP_GT      = 5'd21,
        OP_LE      = 5'd22,
        OP_GE      = 5'd23,
        OP_MIN     = 5'd24,
        OP_MAX     = 5'd25,
        OP_RANGE   = 5'd26
    } t_op;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_DIV   = 2'd1;
    localparam logic [1:0] ERR_SHIFT = 2'd2;

    typedef struct packed {
        logic [4:0]         req_type;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
        logic signed [63:0] operand_c;
    } t_req;

    typedef struct packed {
        logic signed [63:0] result;
        logic [1:0]         error_code;
        logic               verify_failed;
    } t_rsp;

endpackage

[src/svia_mul.sv]
// Two-step wrapping multiplier: registered partial products, then sum.
// Depends on svia_pkg.
module svia_mul import svia_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic [DATA_WIDTH-1:0] o_p
);
    localparam int H  = DATA_WIDTH / 2;
    localparam int HI = DATA_WIDTH - H;

    logic [2*H-1:0] r_p0;
    logic [HI-1:0]  r_p1, r_p2;
    logic [2*H-1:0] n_p0;
    logic [HI-1:0]  n_p1, n_p2;
    logic [H+HI-1:0] w_p1;
    logic [H+HI-1:0] w_p2;

    always_comb begin
        n_p0 = i_a[H-1:0] * i_b[H-1:0];
        w_p1 = i_a[H-1:0] * i_b[DATA_WIDTH-1:H];
        w_p2 = i_a[DATA_WIDTH-1:H] * i_b[H-1:0];
        n_p1 = w_p1[HI-1:0];
        n_p2 = w_p2[HI-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
    end

    // cross terms only matter below bit DATA_WIDTH
    logic [HI-1:0] w_cross;
    assign w_cross = r_p1 + r_p2;
    assign o_p = DATA_WIDTH'(r_p0) + {w_cross, {H{1'b0}}};

endmodule

[src/svia_div.sv]
// Restoring unsigned divider, one quotient bit per pipeline stage.
// Depends on svia_pkg.
module svia_div import svia_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [DATA_WIDTH-1:0] i_num,
    input  logic [DATA_WIDTH-1:0] i_den,
    output logic [DATA_WIDTH-1:0] o_quo,
    output logic [DATA_WIDTH-1:0] o_rem
);
    localparam int DW = DATA_WIDTH;

    logic [DW-1:0] r_rem [DW];
    logic [DW-1:0] r_q   [DW];
    logic [DW-1:0] r_d   [DW];
    logic [DW-1:0] n_rem [DW];
    logic [DW-1:0] n_q   [DW];

    always_comb begin
        logic [DW:0]   trial;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic          ge;
        for (int k = 0; k < DW; k++) begin
            rem_in = (k == 0) ? '0 : r_rem[(k == 0) ? 0 : k-1];
            q_in   = (k == 0) ? i_num : r_q[(k == 0) ? 0 : k-1];
            d_in   = (k == 0) ? i_den : r_d[(k == 0) ? 0 : k-1];
            trial  = {rem_in, q_in[DW-1]};
            ge     = trial >= {1'b0, d_in};
            n_rem[k] = ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
            n_q[k]   = {q_in[DW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DW; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_d[k]   <= (k == 0) ? i_den : r_d[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_quo = r_q[DW-1];
    assign o_rem = r_rem[DW-1];

endmodule

[src/stack_vm_integer_alu.sv]
// Top level of the stack VM integer ALU: decode, simple ops, multiplier,
// divider and result merge. Depends on svia_pkg, svia_mul, svia_div.
//
// One operation enters per cycle unless stalled, and its result passes through
// later: one input register, DATA_WIDTH divider stages (one quotient bit each),
// and the output register. Every operation takes that same path, so
// results leave in order. A full output register that is not taken stalls the
// whole pipeline; otherwise the input is always ready.
module stack_vm_integer_alu import svia_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out
);
    localparam int DW  = DATA_WIDTH;
    localparam int SHW = $clog2(DW);

    typedef struct packed {
        logic [4:0]    op;
        logic [DW-1:0] simple;
        logic [DW-1:0] prod;
        logic [1:0]    err;
        logic          vf;
        logic          neg_q;
        logic          neg_r;
    } t_side;

    logic en;
    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // input stage
    logic                 r_s1_valid;
    logic [4:0]           r_s1_op;
    logic signed [DW-1:0] r_s1_a, r_s1_b, r_s1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
        end
        if (en) begin
            r_s1_op <= i_in.req_type;
            r_s1_a  <= i_in.operand_a[DW-1:0];
            r_s1_b  <= i_in.operand_b[DW-1:0];
            r_s1_c  <= i_in.operand_c[DW-1:0];
        end
    end

    // simple ops and divider setup
    t_side         n_side1;
    logic [DW-1:0] w_mag_a, w_mag_b;

    always_comb begin
        logic lt, gt, eq, shift_ok, is_divop;
        lt = r_s1_a < r_s1_b;
        gt = r_s1_b < r_s1_a;
        eq = r_s1_a == r_s1_b;
        shift_ok = !r_s1_b[DW-1] && (r_s1_b < DW);
        is_divop = (r_s1_op == OP_DIV) || (r_s1_op == OP_MOD);
        n_side1 = '0;
        n_side1.op = r_s1_op;
        case (t_op'(r_s1_op))
            OP_ADD1:    n_side1.simple = r_s1_a + 1'b1;
            OP_SUB1:    n_side1.simple = r_s1_a - 1'b1;
            OP_DOUBLE:  n_side1.simple = {r_s1_a[DW-2:0], 1'b0};
            OP_HALVE:   n_side1.simple = r_s1_a >>> 1;
            OP_NEGATE:  n_side1.simple = -r_s1_a;
            OP_ABS:     n_side1.simple = r_s1_a[DW-1] ? -r_s1_a : r_s1_a;
            OP_NOT:     n_side1.simple = DW'(r_s1_a == 0);
            OP_NONZERO: n_side1.simple = DW'(r_s1_a != 0);
            OP_ADD:     n_side1.simple = r_s1_a + r_s1_b;
            OP_SUB:     n_side1.simple = r_s1_a - r_s1_b;
            OP_SHL: begin
                if (shift_ok) n_side1.simple = r_s1_a << r_s1_b[SHW-1:0];
                else n_side1.err = ERR_SHIFT;
            end
            OP_SHR: begin
                if (shift_ok) n_side1.simple = r_s1_a >>> r_s1_b[SHW-1:0];
                else n_side1.err = ERR_SHIFT;
            end
            OP_BOOLAND: n_side1.simple = DW'((r_s1_a != 0) && (r_s1_b != 0));
            OP_BOOLOR:  n_side1.simple = DW'((r_s1_a != 0) || (r_s1_b != 0));
            OP_EQ:      n_side1.simple = DW'(eq);
            OP_EQVER: begin
                n_side1.simple = DW'(eq);
                n_side1.vf     = !eq;
            end
            OP_NE:      n_side1.simple = DW'(!eq);
            OP_LT:      n_side1.simple = DW'(lt);
            OP_GT:      n_side1.simple = DW'(gt);
            OP_LE:      n_side1.simple = DW'(!gt);
            OP_GE:      n_side1.simple = DW'(!lt);
            OP_MIN:     n_side1.simple = lt ? r_s1_a : r_s1_b;
            OP_MAX:     n_side1.simple = gt ? r_s1_a : r_s1_b;
            OP_RANGE:   n_side1.simple = DW'(!lt && (r_s1_a < r_s1_c));
            default:    n_side1.simple = '0;
        endcase
        // zero divisor, or most negative over minus one
        if (is_divop && ((r_s1_b == 0) ||
                (r_s1_a == {1'b1, {(DW-1){1'b0}}} && r_s1_b == '1)))
            n_side1.err = ERR_DIV;
        n_side1.neg_q = r_s1_a[DW-1] ^ r_s1_b[DW-1];
        n_side1.neg_r = r_s1_a[DW-1];
        w_mag_a = r_s1_a[DW-1] ? -r_s1_a : r_s1_a;
        w_mag_b = r_s1_b[DW-1] ? -r_s1_b : r_s1_b;
    end

    logic [DW-1:0] w_prod, w_quo, w_rem;

    svia_mul #(.DATA_WIDTH(DW)) u_mul (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_s1_a),
        .i_b   (r_s1_b),
        .o_p   (w_prod)
    );

    svia_div #(.DATA_WIDTH(DW)) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (w_mag_a),
        .i_den (w_mag_b),
        .o_quo (w_quo),
        .o_rem (w_rem)
    );

    // side data travels alongside the divider stages
    t_side r_side [DW];
    logic  r_v    [DW];
    t_side w_side1;

    // product joins the side data one stage in
    always_comb begin
        w_side1      = r_side[0];
        w_side1.prod = w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DW; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= r_s1_valid;
            for (int k = 1; k < DW; k++) r_v[k] <= r_v[k-1];
        end
        if (en) begin
            r_side[0] <= n_side1;
            r_side[1] <= w_side1;
            for (int k = 2; k < DW; k++) r_side[k] <= r_side[k-1];
        end
    end

    // merge and output register
    t_side         w_last;
    logic [DW-1:0] n_res;
    t_rsp          r_out;
    logic          r_out_valid;

    assign w_last = r_side[DW-1];

    always_comb begin
        case (t_op'(w_last.op))
            OP_MUL: n_res = w_last.prod;
            OP_DIV: n_res = (w_last.err != ERR_OK) ? '0 :
                            (w_last.neg_q ? -w_quo : w_quo);
            OP_MOD: n_res = (w_last.err != ERR_OK) ? '0 :
                            (w_last.neg_r ? -w_rem : w_rem);
            default: n_res = w_last.simple;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v[DW-1];
        end
        if (en) begin
            r_out.result        <= 64'($signed(n_res));
            r_out.error_code    <= w_last.err;
            r_out.verify_failed <= w_last.vf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_vf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.verify_failed |->
            o_out.error_code == ERR_OK && o_out.result == 64'd0)
        else $error("verify failure with nonzero result or error");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.error_code != 2'd3)
        else $error("illegal error code");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_s1_valid)
        else $error("accepted item lost at input stage");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("stall without a held result");

endmodule
